@@ sv/char_histogram_first_seen_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the character histogram
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CHAR_HISTOGRAM_FIRST_SEEN_TOP_MACROS_SVH
`define CHAR_HISTOGRAM_FIRST_SEEN_TOP_MACROS_SVH

// same-cycle implication
`define CHFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/chfs_pkg.sv @@
// ----------------------------------------------------------------------------
// chfs_pkg
// Sizes, character constants and state codes for the character histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package chfs_pkg;

    localparam int ENTRIES    = 32;
    localparam int COUNT_BITS = 16;
    localparam int SYM_W      = 8;
    localparam int TALLY_W    = 16;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = SYM_W + COUNT_BITS;

    localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [SYM_W-1:0] CASE_OFFSET  = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UPD  = 3'b010,
        ST_RPT  = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ sv/char_histogram_first_seen_top.sv @@
// Update: a character already in the table is read, then its count is written back in
// the update state; a new or dropped character is taken in the idle state. Report: once
// the end-of-text character is counted, each entry is read, registered and sent, paced
// by the single registered read port of the count memory; a read waits for the last one.
// Reset: entry count and overflow flag cleared; table contents left as they are.
// ----------------------------------------------------------------------------
// char_histogram_first_seen_top
// Character histogram with first-seen ordering. Symbols sit in a register row
// for the parallel lookup; symbol and count words sit in a synchronous memory
// that is read, incremented and written back. End of text dumps the table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_histogram_first_seen_top_macros.svh"

module char_histogram_first_seen_top
    import chfs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] ch
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,   // [7:0] symbol, [23:8] tally
    output logic              m_tuser,   // [0] dropped
    output logic              m_tlast
);

    // table storage
    logic [SYM_W-1:0]  sym_tab [ENTRIES];
    logic [WORD_W-1:0] mem     [ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;

    // control
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              ovf_reg, ovf_next;
    logic [IDX_W-1:0]  upd_idx_reg, upd_idx_next;
    logic              eot_reg, eot_next;
    logic [IDX_W-1:0]  rpt_idx_reg, rpt_idx_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;
    logic              pend_drop_reg, pend_drop_next;

    // output beat
    logic              m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]  m_sym_reg;
    logic [TALLY_W-1:0] m_tally_reg;
    logic              m_drop_reg;
    logic              m_last_reg;

    logic [SYM_W-1:0]      sym_fold;
    logic [ENTRIES-1:0]    match;
    logic                  hit;
    logic                  full;
    logic [IDX_W-1:0]      hit_idx;
    logic                  s_fire;
    logic                  sym_we;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr, mem_raddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [COUNT_BITS-1:0] cur_tally, inc_tally;
    logic                  rpt_issue, rpt_last;
    logic [31:0]           rd_tally32;
    logic [TALLY_W-1:0]    rd_tally_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign sym_fold = (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_Z) ?
                      s_tdata + CASE_OFFSET : s_tdata;

    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            match[k] = (CNT_W'(k) < used_reg) && (sym_tab[k] == sym_fold);
            if (match[k]) begin
                hit_idx = hit_idx | IDX_W'(k);
            end
        end
    end

    assign hit  = |match;
    assign full = (used_reg == CNT_W'(ENTRIES));

    assign cur_tally = rd_data_reg[COUNT_BITS-1:0];
    assign inc_tally = (cur_tally == '1) ? cur_tally : cur_tally + COUNT_BITS'(1);

    assign rpt_issue = (state_reg == ST_RPT) && !pend_reg && (!m_valid_reg || m_tready);
    assign rpt_last  = ((CNT_W'(rpt_idx_reg) + CNT_W'(1)) == used_reg);

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        ovf_next       = ovf_reg;
        upd_idx_next   = upd_idx_reg;
        eot_next       = eot_reg;
        rpt_idx_next   = rpt_idx_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        pend_drop_next = pend_drop_reg;
        sym_we         = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = used_reg[IDX_W-1:0];
        mem_raddr      = hit_idx;
        mem_wdata      = {sym_fold, COUNT_BITS'(1)};

        unique case (state_reg)
            ST_IDLE: begin
                rpt_idx_next = '0;
                if (s_fire) begin
                    if (hit) begin
                        mem_re       = 1'b1;
                        mem_raddr    = hit_idx;
                        upd_idx_next = hit_idx;
                        eot_next     = s_tlast;
                        state_next   = ST_UPD;
                    end else begin
                        if (!full) begin
                            sym_we    = 1'b1;
                            mem_we    = 1'b1;
                            used_next = used_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                        state_next = s_tlast ? ST_RPT : ST_IDLE;
                    end
                end
            end
            ST_UPD: begin
                mem_we     = 1'b1;
                mem_waddr  = upd_idx_reg;
                mem_wdata  = {rd_data_reg[WORD_W-1:COUNT_BITS], inc_tally};
                state_next = eot_reg ? ST_RPT : ST_IDLE;
            end
            ST_RPT: begin
                if (rpt_issue) begin
                    mem_re         = 1'b1;
                    mem_raddr      = rpt_idx_reg;
                    pend_next      = 1'b1;
                    pend_last_next = rpt_last;
                    pend_drop_next = ovf_reg;
                    if (rpt_last) begin
                        used_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        rpt_idx_next = rpt_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (pend_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            ovf_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            ovf_reg     <= ovf_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        upd_idx_reg   <= upd_idx_next;
        eot_reg       <= eot_next;
        rpt_idx_reg   <= rpt_idx_next;
        pend_last_reg <= pend_last_next;
        pend_drop_reg <= pend_drop_next;
    end

    // symbol row for the lookup
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_tab[used_reg[IDX_W-1:0]] <= sym_fold;
        end
    end

    // symbol and count memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rd_tally32   = 32'(cur_tally);
    assign rd_tally_sat = (rd_tally32 > 32'h0000_FFFF) ? '1 : rd_tally32[TALLY_W-1:0];

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            m_sym_reg   <= rd_data_reg[WORD_W-1:COUNT_BITS];
            m_tally_reg <= rd_tally_sat;
            m_drop_reg  <= pend_drop_reg;
            m_last_reg  <= pend_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_tally_reg, m_sym_reg};
    assign m_tuser  = m_drop_reg;
    assign m_tlast  = m_last_reg;

    `CHFS_ASSERT_IMP(a_used_bound, 1'b1, used_reg <= CNT_W'(ENTRIES), "entry count past table size")
    `CHFS_ASSERT_IMP(a_unique_hit, s_fire, $onehot0(match), "symbol held in more than one entry")
    `CHFS_ASSERT_IMP(a_no_clobber, pend_reg, !m_valid_reg || m_tready, "report beat overwrites held beat")
    `CHFS_ASSERT_NXT(a_rpt_clear, rpt_issue && rpt_last, state_reg == ST_IDLE && used_reg == '0 && !ovf_reg, "table not cleared after report")
    `CHFS_ASSERT_NXT(a_upd_follows, s_fire && hit, state_reg == ST_UPD, "count update skipped")

endmodule

`default_nettype wire
